[hw/rtl/rsbt_pkg.sv]
// Package for the record sorter: sizes, request and result types, stored
// record layout, control states and the sort key compare.
// Has no dependencies; used by the top level and its checker.
package rsbt_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int TOTAL_W     = 9;

    typedef struct packed {
        logic [7:0]  math_mark;
        logic [7:0]  english_mark;
        logic [19:0] student_id;
        logic [3:0]  class_number;
        logic [7:0]  section_letter;
        logic [15:0] name_tag;
        logic        is_last;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_math_mark;
        logic [7:0]  out_english_mark;
        logic [19:0] out_student_id;
        logic [3:0]  out_class_number;
        logic [7:0]  out_section_letter;
        logic [15:0] out_name_tag;
        logic        out_last;
        logic        overflowed;
    } t_out;

    typedef struct packed {
        logic [7:0]  math_mark;
        logic [7:0]  english_mark;
        logic [19:0] student_id;
        logic [3:0]  class_number;
        logic [7:0]  section_letter;
        logic [15:0] name_tag;
    } t_rec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_HOLD
    } t_state;

    function automatic logic [TOTAL_W-1:0] rec_total(input t_rec r);
        return TOTAL_W'(r.math_mark) + TOTAL_W'(r.english_mark);
    endfunction

    // True when key (sa, ia) sorts strictly ahead of key (sb, ib).
    function automatic logic goes_before(input logic [TOTAL_W-1:0] sa,
                                         input logic [19:0] ia,
                                         input logic [TOTAL_W-1:0] sb,
                                         input logic [19:0] ib);
        if (sa != sb) begin
            return sa > sb;
        end
        return ia < ib;
    endfunction

endpackage

[hw/rtl/record_sort_by_total_then_id_unit.sv]
// Top level of the record sorter: one record RAM kept in key order by insertion.
// Depends on rsbt_pkg for types, sizes, states and the key compare.
// Load: a request into an empty store goes straight to the write, else the scan moves one stored
// entry per cycle until the new record's slot is found; a request dropped by a full store sets the overflow flag.
// Emit: a read state to start, then a wait and a hold state per result; the hold lasts while the output is stalled.
// Reset clears the count, the overflow flag, the controller and the output valid, not the RAM.
module record_sort_by_total_then_id_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rsbt_pkg::t_in i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rsbt_pkg::t_out o_out_data
);

    rsbt_pkg::t_rec mem [rsbt_pkg::MAX_RECORDS];

    rsbt_pkg::t_state r_state, n_state;
    logic [rsbt_pkg::CNT_W-1:0]   r_count, n_count;
    logic [rsbt_pkg::CNT_W-1:0]   r_pos, n_pos;
    logic [rsbt_pkg::ADDR_W-1:0]  r_ptr, n_ptr;
    logic                         r_ovf, n_ovf;
    logic                         r_out_valid, n_out_valid;
    rsbt_pkg::t_out               r_out, n_out;
    rsbt_pkg::t_rec               r_new, n_new;
    logic                         r_new_last, n_new_last;
    logic [rsbt_pkg::TOTAL_W-1:0] r_new_total, n_new_total;
    rsbt_pkg::t_rec               r_rd;

    logic [rsbt_pkg::ADDR_W-1:0]  rd_addr;
    logic                         wr_en;
    logic [rsbt_pkg::ADDR_W-1:0]  wr_addr;
    rsbt_pkg::t_rec               wr_data;
    logic                         in_accept;
    logic                         is_final;

    assign o_in_stall  = (r_state != rsbt_pkg::ST_IDLE);
    assign in_accept   = i_in_valid && (r_state == rsbt_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign is_final    = ({1'b0, r_ptr} == (r_count - rsbt_pkg::CNT_W'(1)));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsbt_pkg::ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_ptr       <= n_ptr;
        r_out       <= n_out;
        r_new       <= n_new;
        r_new_last  <= n_new_last;
        r_new_total <= n_new_total;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_ptr       = r_ptr;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_new       = r_new;
        n_new_last  = r_new_last;
        n_new_total = r_new_total;
        rd_addr     = r_ptr;
        wr_en       = 1'b0;
        wr_addr     = r_pos[rsbt_pkg::ADDR_W-1:0];
        wr_data     = r_new;

        case (r_state)
            rsbt_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_new.math_mark      = i_in_data.math_mark;
                    n_new.english_mark   = i_in_data.english_mark;
                    n_new.student_id     = i_in_data.student_id;
                    n_new.class_number   = i_in_data.class_number;
                    n_new.section_letter = i_in_data.section_letter;
                    n_new.name_tag       = i_in_data.name_tag;
                    n_new_last           = i_in_data.is_last;
                    n_new_total          = rsbt_pkg::rec_total(n_new);
                    n_pos                = r_count;
                    n_ptr                = '0;
                    if (r_count == rsbt_pkg::CNT_W'(rsbt_pkg::MAX_RECORDS)) begin
                        n_ovf = 1'b1;
                        if (i_in_data.is_last) begin
                            n_state = rsbt_pkg::ST_EMIT_RD;
                        end
                    end else if (r_count == '0) begin
                        n_state = rsbt_pkg::ST_PLACE;
                    end else begin
                        rd_addr = rsbt_pkg::ADDR_W'(r_count - rsbt_pkg::CNT_W'(1));
                        n_state = rsbt_pkg::ST_SCAN;
                    end
                end
            end
            rsbt_pkg::ST_SCAN: begin
                if (rsbt_pkg::goes_before(r_new_total, r_new.student_id,
                                          rsbt_pkg::rec_total(r_rd), r_rd.student_id)) begin
                    wr_en   = 1'b1;
                    wr_data = r_rd;
                    n_pos   = r_pos - rsbt_pkg::CNT_W'(1);
                    if (n_pos == '0) begin
                        n_state = rsbt_pkg::ST_PLACE;
                    end else begin
                        rd_addr = rsbt_pkg::ADDR_W'(r_pos - rsbt_pkg::CNT_W'(2));
                    end
                end else begin
                    n_state = rsbt_pkg::ST_PLACE;
                end
            end
            rsbt_pkg::ST_PLACE: begin
                wr_en   = 1'b1;
                wr_data = r_new;
                n_count = r_count + rsbt_pkg::CNT_W'(1);
                n_state = r_new_last ? rsbt_pkg::ST_EMIT_RD : rsbt_pkg::ST_IDLE;
            end
            rsbt_pkg::ST_EMIT_RD: begin
                rd_addr = r_ptr;
                n_state = rsbt_pkg::ST_EMIT_WAIT;
            end
            rsbt_pkg::ST_EMIT_WAIT: begin
                n_out.out_math_mark      = r_rd.math_mark;
                n_out.out_english_mark   = r_rd.english_mark;
                n_out.out_student_id     = r_rd.student_id;
                n_out.out_class_number   = r_rd.class_number;
                n_out.out_section_letter = r_rd.section_letter;
                n_out.out_name_tag       = r_rd.name_tag;
                n_out.out_last           = is_final;
                n_out.overflowed         = r_ovf;
                n_out_valid              = 1'b1;
                n_state                  = rsbt_pkg::ST_EMIT_HOLD;
            end
            rsbt_pkg::ST_EMIT_HOLD: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (is_final) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = rsbt_pkg::ST_IDLE;
                    end else begin
                        n_ptr   = r_ptr + rsbt_pkg::ADDR_W'(1);
                        rd_addr = n_ptr;
                        n_state = rsbt_pkg::ST_EMIT_WAIT;
                    end
                end
            end
            default: begin
                n_state = rsbt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/rsbt_checker.sv]
// Port-level checker for the record sorter, bound to the top level.
// Depends on rsbt_pkg for the request and result types.
module rsbt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input rsbt_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input rsbt_pkg::t_out o_out_data
);

    // No result is shown in the cycle after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Requests are never taken while results are being delivered.
    a_no_load_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request port open during emit");

    // The final result of a batch ends the output burst.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_data.out_last |=> !o_out_valid)
        else $error("result shown after final result");

    // The overflow mark stays the same across one batch of results.
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.out_last ##2 o_out_valid
        |-> o_out_data.overflowed == $past(o_out_data.overflowed, 2))
        else $error("overflow mark changed inside a batch");

endmodule

bind record_sort_by_total_then_id_unit rsbt_checker u_rsbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[test/rsbt_order_checker.sv]
// Checker for the record sorter: watches both channels, keeps its own sorted copy of the batch
// and compares every emitted record against the expected order.
// Depends on rsbt_pkg for the request and result types and the store size.
`timescale 1ns / 1ps

module rsbt_order_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  rsbt_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  rsbt_pkg::t_out i_out_data,
    output int             o_err_cnt,
    output int             o_pending
);

    rsbt_pkg::t_rec held [rsbt_pkg::MAX_RECORDS];
    int             held_n  = 0;
    logic           dropped = 1'b0;
    rsbt_pkg::t_out due_q [$];
    int             err_cnt = 0;

    function automatic logic [8:0] total_of(input rsbt_pkg::t_rec r);
        return {1'b0, r.math_mark} + {1'b0, r.english_mark};
    endfunction

    function automatic bit ranks_ahead(input rsbt_pkg::t_rec a, input rsbt_pkg::t_rec b);
        if (total_of(a) != total_of(b)) begin
            return total_of(a) > total_of(b);
        end
        return a.student_id < b.student_id;
    endfunction

    function automatic bit field_bad(input string fname, input logic [19:0] want,
                                     input logic [19:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic take_request(input rsbt_pkg::t_in req);
        rsbt_pkg::t_rec r;
        rsbt_pkg::t_out res;
        int             pos;
        r.math_mark      = req.math_mark;
        r.english_mark   = req.english_mark;
        r.student_id     = req.student_id;
        r.class_number   = req.class_number;
        r.section_letter = req.section_letter;
        r.name_tag       = req.name_tag;
        if (held_n < rsbt_pkg::MAX_RECORDS) begin
            pos = held_n;
            while (pos > 0 && ranks_ahead(r, held[pos-1])) begin
                held[pos] = held[pos-1];
                pos--;
            end
            held[pos] = r;
            held_n++;
        end else begin
            dropped = 1'b1;
        end
        if (req.is_last) begin
            for (int k = 0; k < held_n; k++) begin
                res.out_math_mark      = held[k].math_mark;
                res.out_english_mark   = held[k].english_mark;
                res.out_student_id     = held[k].student_id;
                res.out_class_number   = held[k].class_number;
                res.out_section_letter = held[k].section_letter;
                res.out_name_tag       = held[k].name_tag;
                res.out_last           = (k == held_n - 1);
                res.overflowed         = dropped;
                due_q.push_back(res);
            end
            held_n  = 0;
            dropped = 1'b0;
        end
    endtask

    task automatic take_result(input rsbt_pkg::t_out got);
        rsbt_pkg::t_out want;
        bit             bad;
        if (due_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            err_cnt++;
        end else begin
            want = due_q.pop_front();
            bad = field_bad("out_math_mark", 20'(want.out_math_mark), 20'(got.out_math_mark))
                | field_bad("out_english_mark", 20'(want.out_english_mark),
                            20'(got.out_english_mark))
                | field_bad("out_student_id", want.out_student_id, got.out_student_id)
                | field_bad("out_class_number", 20'(want.out_class_number),
                            20'(got.out_class_number))
                | field_bad("out_section_letter", 20'(want.out_section_letter),
                            20'(got.out_section_letter))
                | field_bad("out_name_tag", 20'(want.out_name_tag), 20'(got.out_name_tag))
                | field_bad("out_last", 20'(want.out_last), 20'(got.out_last))
                | field_bad("overflowed", 20'(want.overflowed), 20'(got.overflowed));
            if (bad) begin
                err_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_n  = 0;
            dropped = 1'b0;
            due_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                take_request(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                take_result(i_out_data);
            end
        end
        o_err_cnt <= err_cnt;
        o_pending <= due_q.size();
    end

endmodule

[test/tb_record_sort_by_total_then_id_unit.sv]
// Testbench top for the record sorter: drives directed and random batches with random gaps
// and output stalls, and gives the verdict from the failure and pending counts of rsbt_order_checker.
// Depends on rsbt_pkg, record_sort_by_total_then_id_unit and rsbt_order_checker.
`timescale 1ns / 1ps

module tb_record_sort_by_total_then_id_unit;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    rsbt_pkg::t_in  i_in_data   = '0;
    logic           i_out_stall = 1'b0;
    logic           o_in_stall;
    logic           o_out_valid;
    rsbt_pkg::t_out o_out_data;
    logic           quiet       = 1'b0;
    logic [3:0]     hold_cnt    = '0;
    int             err_cnt;
    int             pending;
    int             sent        = 0;

    always #2 i_clk = ~i_clk;

    record_sort_by_total_then_id_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    rsbt_order_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .o_err_cnt   (err_cnt),
        .o_pending   (pending)
    );

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 14);
    endfunction

    always @(posedge i_clk) begin : out_side
        int n;
        if (!i_rst_n) begin
            hold_cnt    <= '0;
            i_out_stall <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            n = draw_wait();
            hold_cnt    <= 4'(n);
            i_out_stall <= (n != 0);
        end else if (hold_cnt != 0) begin
            hold_cnt    <= hold_cnt - 4'd1;
            i_out_stall <= (hold_cnt > 4'd1);
        end
    end

    function automatic rsbt_pkg::t_in make_req(input logic [7:0] m, input logic [7:0] e,
                                               input logic [19:0] id, input logic [3:0] cls,
                                               input logic [7:0] sec, input logic [15:0] tag,
                                               input logic last);
        rsbt_pkg::t_in r;
        r.math_mark      = m;
        r.english_mark   = e;
        r.student_id     = id;
        r.class_number   = cls;
        r.section_letter = sec;
        r.name_tag       = tag;
        r.is_last        = last;
        return r;
    endfunction

    function automatic rsbt_pkg::t_in random_req(input logic last);
        rsbt_pkg::t_in r;
        r = rsbt_pkg::t_in'({1'b0, $urandom, $urandom});
        r.math_mark = 8'($urandom);
        if ($urandom_range(0, 1) == 0) begin
            r.math_mark    = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                  : 8'($urandom_range(252, 255));
            r.english_mark = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                  : 8'($urandom_range(252, 255));
            r.student_id   = 20'($urandom_range(0, 3));
        end
        r.is_last = last;
        return r;
    endfunction

    task automatic send_request(input rsbt_pkg::t_in req);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int size;
        int batch;
        int start_cnt;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(make_req(8'd0, 8'd0, 20'd0, 4'd0, 8'd0, 16'd0, 1'b1));
        send_request(make_req(8'hFF, 8'hFF, 20'hFFFFF, 4'hF, 8'hFF, 16'hFFFF, 1'b1));

        send_request(make_req(8'd60, 8'd40, 20'd5, 4'd1, 8'h41, 16'd1, 1'b0));
        send_request(make_req(8'd40, 8'd60, 20'd5, 4'd2, 8'h42, 16'd2, 1'b0));
        send_request(make_req(8'd50, 8'd50, 20'd3, 4'd3, 8'h43, 16'd3, 1'b0));
        send_request(make_req(8'hFF, 8'hFF, 20'hFFFFF, 4'd4, 8'h44, 16'd4, 1'b0));
        send_request(make_req(8'd0, 8'd0, 20'd0, 4'd5, 8'h45, 16'd5, 1'b0));
        send_request(make_req(8'd100, 8'd0, 20'd5, 4'd6, 8'h46, 16'd6, 1'b0));
        send_request(make_req(8'hFF, 8'd1, 20'd7, 4'd7, 8'h47, 16'd7, 1'b0));
        send_request(make_req(8'd1, 8'hFF, 20'd6, 4'd8, 8'h48, 16'd8, 1'b0));
        send_request(make_req(8'd0, 8'd1, 20'hFFFFF, 4'd9, 8'h49, 16'd9, 1'b1));

        send_request(make_req(8'd200, 8'd200, 20'd1, 4'd10, 8'h61, 16'h1111, 1'b0));
        send_request(make_req(8'd150, 8'd150, 20'd2, 4'd11, 8'h62, 16'h2222, 1'b0));
        send_request(make_req(8'd100, 8'd100, 20'd3, 4'd12, 8'h63, 16'h3333, 1'b0));
        send_request(make_req(8'd90, 8'd90, 20'd4, 4'd13, 8'h64, 16'h4444, 1'b1));
        send_request(make_req(8'd10, 8'd10, 20'd9, 4'd14, 8'h65, 16'h5555, 1'b0));
        send_request(make_req(8'd20, 8'd20, 20'd8, 4'd15, 8'h66, 16'h6666, 1'b0));
        send_request(make_req(8'd30, 8'd30, 20'd7, 4'd0, 8'h67, 16'h7777, 1'b1));
        wait_drained();

        start_cnt = sent;
        batch = 0;
        while (sent - start_cnt < 280) begin
            if (batch == 1) begin
                size = rsbt_pkg::MAX_RECORDS;
            end else if (batch == 4) begin
                size = rsbt_pkg::MAX_RECORDS + $urandom_range(1, 3);
            end else begin
                size = $urandom_range(1, 10);
            end
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < size; k++) begin
                send_request(random_req(k == size - 1));
            end
            if (size >= rsbt_pkg::MAX_RECORDS || $urandom_range(0, 7) == 0) begin
                wait_drained();
            end
            batch++;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && pending == 0) begin
            $display("tb_record_sort_by_total_then_id_unit: PASS");
        end else begin
            $display("tb_record_sort_by_total_then_id_unit: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("tb_record_sort_by_total_then_id_unit: FAIL");
        $finish;
    end

endmodule
